### design/vrt_pkg.sv
package vrt_pkg;

	localparam int GRID_BITS  = 5;
	localparam int BLOCK_BITS = 8;
	localparam int FRAC_BITS  = 12;
	localparam int DIR_FRAC   = 14;

	localparam int ORG_W   = GRID_BITS + FRAC_BITS;
	localparam int MAXD_W  = FRAC_BITS + 6;
	localparam int DIST_W  = FRAC_BITS + 7;
	localparam int ADDR_W  = 3 * GRID_BITS;
	localparam int POS_W   = GRID_BITS + 2;
	localparam int DIR_W   = 16;
	localparam int NUM_W   = FRAC_BITS + DIR_FRAC + 1;
	localparam int FRAC_W  = FRAC_BITS + 1;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [FRAC_BITS-1:0] FACE_TOL =
		FRAC_BITS'((1 << FRAC_BITS) / 1000 + 1);

	localparam logic [2:0] FACE_NONE = 3'd0;

	typedef struct packed {
		logic        cmd;
		logic [4:0]  voxel_x;
		logic [4:0]  voxel_y;
		logic [4:0]  voxel_z;
		logic [7:0]  block_value;
		logic [16:0] origin_x;
		logic [16:0] origin_y;
		logic [16:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [17:0] max_distance;
	} item_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] hit_block;
		logic [4:0] hit_x;
		logic [4:0] hit_y;
		logic [4:0] hit_z;
		logic [2:0] face;
	} result_t;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

endpackage

### design/voxel_ray_traversal.sv
// Channel   Ports                                   Handshake
// item      start, busy, item                       taken when start && !busy
// result    valid, result                           one cycle, no back pressure
// config    psel penable pwrite paddr pwdata prdata write on access, pready high
//
// A write item goes into the store as it is taken, and the block stays idle.
// A cast sets up each moving axis in turn on two shared dividers, then visits
// voxels on the store's single read port, and on a hit tests the face axes in turn.
// After reset the store's 32768 entries are swept to zero, one entry a cycle,
// with busy high; configuration writes are taken meanwhile.
// Results cannot be stalled.
module voxel_ray_traversal (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  vrt_pkg::item_t    item,
	output logic              valid,
	output vrt_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import vrt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DGO  = 3'd1;
	localparam logic [2:0] S_DWT  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;
	localparam logic [2:0] S_FMUL = 3'd5;
	localparam logic [2:0] S_FTST = 3'd6;

	localparam int PROD_W = DIR_W + DIST_W + 1;

	logic [2:0] state_q;
	logic [7:0] empty_q;

	logic [2:0][ORG_W-1:0]  org_q;
	logic [2:0][DIR_W-1:0]  dir_q;
	logic [2:0][POS_W-1:0]  pos_q;
	logic [2:0][DIST_W-1:0] tmax_q;
	logic [2:0][DIST_W-1:0] tdel_q;
	logic [2:0]             act_q;
	logic [MAXD_W-1:0]      maxd_q;
	logic [DIST_W-1:0]      dist_q;
	logic [1:0]             ax_q;
	logic [BLOCK_BITS-1:0]  blk_q;
	logic signed [PROD_W-1:0] prod_q;
	result_t                result_q;
	logic                   valid_q;

	logic clearing;
	logic accept;
	logic cfg_wr;

	// store
	logic                  st_wr;
	logic                  st_rd;
	logic [ADDR_W-1:0]     st_raddr;
	logic [BLOCK_BITS-1:0] st_rdata;

	// dividers
	logic                  div_go;
	logic [DIR_W-1:0]      mag;
	logic [FRAC_W-1:0]     fr;
	logic [NUM_W-1:0]      num_tmax;
	logic [NUM_W-1:0]      q_tmax;
	logic [NUM_W-1:0]      q_tdel;
	logic                  d_done_a;
	logic                  d_done_b;

	logic                  out_grid;
	logic [DIST_W:0]       key0, key1, key2;
	logic [1:0]            step_ax;
	logic [DIST_W:0]       tsum;
	logic signed [PROD_W-1:0] prod_sh;
	logic [FRAC_BITS-1:0]  pfrac;
	logic [DIR_W-1:0]      cur_dir;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE) || clearing;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {24'd0, empty_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			empty_q <= '0;
		else if (cfg_wr && !paddr[2])
			empty_q <= pwdata[7:0];
	end

	assign st_wr    = accept && (item.cmd == CMD_WRITE);
	assign st_rd    = (state_q == S_RD) && (dist_q <= {1'b0, maxd_q}) && !out_grid;
	assign st_raddr = {pos_q[0][GRID_BITS-1:0], pos_q[1][GRID_BITS-1:0],
		pos_q[2][GRID_BITS-1:0]};

	vrt_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (st_wr),
		.wr_addr  ({item.voxel_x, item.voxel_y, item.voxel_z}),
		.wr_data  (item.block_value[BLOCK_BITS-1:0]),
		.rd_en    (st_rd),
		.rd_addr  (st_raddr),
		.rd_data  (st_rdata),
		.clearing (clearing)
	);

	assign cur_dir  = dir_q[ax_q];
	assign mag      = cur_dir[DIR_W-1] ? DIR_W'(-cur_dir) : cur_dir;
	assign fr       = (!cur_dir[DIR_W-1])
		? FRAC_W'((1 << FRAC_BITS) - {1'b0, org_q[ax_q][FRAC_BITS-1:0]})
		: {1'b0, org_q[ax_q][FRAC_BITS-1:0]};
	assign num_tmax = {fr, {DIR_FRAC{1'b0}}};
	assign div_go   = (state_q == S_DGO) && act_q[ax_q];

	vrt_div u_div_max (
		.clk (clk), .arst_n (arst_n), .start (div_go),
		.num (num_tmax), .den (mag), .done (d_done_a), .quo (q_tmax)
	);

	vrt_div u_div_del (
		.clk (clk), .arst_n (arst_n), .start (div_go),
		.num (NUM_W'(1) << (FRAC_BITS + DIR_FRAC)), .den (mag),
		.done (d_done_b), .quo (q_tdel)
	);

	assign out_grid = pos_q[0][POS_W-1:GRID_BITS] != '0
		|| pos_q[1][POS_W-1:GRID_BITS] != '0
		|| pos_q[2][POS_W-1:GRID_BITS] != '0;

	// pick the axis with the nearest boundary; idle axes sort last
	always_comb begin
		key0 = act_q[0] ? {1'b0, tmax_q[0]} : {1'b1, {DIST_W{1'b0}}};
		key1 = act_q[1] ? {1'b0, tmax_q[1]} : {1'b1, {DIST_W{1'b0}}};
		key2 = act_q[2] ? {1'b0, tmax_q[2]} : {1'b1, {DIST_W{1'b0}}};
		if (key0 < key1)
			step_ax = (key0 < key2) ? 2'd0 : 2'd2;
		else
			step_ax = (key1 < key2) ? 2'd1 : 2'd2;
		tsum = {1'b0, tmax_q[step_ax]} + {1'b0, tdel_q[step_ax]};
	end

	assign prod_sh = prod_q >>> DIR_FRAC;
	assign pfrac   = org_q[ax_q][FRAC_BITS-1:0] + prod_sh[FRAC_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			ax_q    <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					ax_q <= '0;
					if (accept && item.cmd == CMD_CAST)
						state_q <= S_DGO;
				end
				S_DGO: begin
					if (act_q[ax_q])
						state_q <= S_DWT;
					else if (ax_q == 2'd2)
						state_q <= S_RD;
					else
						ax_q <= ax_q + 1'b1;
				end
				S_DWT: begin
					if (d_done_a) begin
						if (ax_q == 2'd2) begin
							state_q <= S_RD;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= S_DGO;
						end
					end
				end
				S_RD: begin
					if (!st_rd) begin
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					ax_q <= '0;
					if (st_rdata != empty_q[BLOCK_BITS-1:0])
						state_q <= S_FMUL;
					else if (!act_q[step_ax]) begin
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else
						state_q <= S_RD;
				end
				S_FMUL: state_q <= S_FTST;
				S_FTST: begin
					if (pfrac < FACE_TOL || ax_q == 2'd2) begin
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_FMUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				org_q[0] <= item.origin_x;
				org_q[1] <= item.origin_y;
				org_q[2] <= item.origin_z;
				dir_q[0] <= item.dir_x;
				dir_q[1] <= item.dir_y;
				dir_q[2] <= item.dir_z;
				act_q    <= {item.dir_z != '0, item.dir_y != '0, item.dir_x != '0};
				pos_q[0] <= POS_W'(item.origin_x[ORG_W-1:FRAC_BITS]);
				pos_q[1] <= POS_W'(item.origin_y[ORG_W-1:FRAC_BITS]);
				pos_q[2] <= POS_W'(item.origin_z[ORG_W-1:FRAC_BITS]);
				maxd_q   <= item.max_distance;
				dist_q   <= '0;
				tmax_q   <= {3{DIST_MAX}};
				tdel_q   <= {3{DIST_MAX}};
				result_q <= '0;
			end
			S_DWT: begin
				if (d_done_a) begin
					tmax_q[ax_q] <= (q_tmax > NUM_W'(DIST_MAX)) ? DIST_MAX
						: q_tmax[DIST_W-1:0];
					tdel_q[ax_q] <= (q_tdel > NUM_W'(DIST_MAX)) ? DIST_MAX
						: q_tdel[DIST_W-1:0];
				end
			end
			S_RD: begin
				if (!st_rd)
					result_q <= '0;
			end
			S_CHK: begin
				blk_q <= st_rdata;
				if (st_rdata == empty_q[BLOCK_BITS-1:0] && act_q[step_ax]) begin
					// advance one voxel along the chosen axis
					pos_q[step_ax] <= dir_q[step_ax][DIR_W-1]
						? pos_q[step_ax] - 1'b1 : pos_q[step_ax] + 1'b1;
					dist_q         <= tmax_q[step_ax];
					tmax_q[step_ax] <= tsum[DIST_W] ? DIST_MAX : tsum[DIST_W-1:0];
				end else if (st_rdata == empty_q[BLOCK_BITS-1:0]) begin
					result_q <= '0;
				end
			end
			S_FMUL: begin
				prod_q <= PROD_W'($signed(dir_q[ax_q]) * $signed({1'b0, dist_q}));
			end
			S_FTST: begin
				result_q.hit       <= 1'b1;
				result_q.hit_block <= 8'(blk_q);
				result_q.hit_x     <= pos_q[0][GRID_BITS-1:0];
				result_q.hit_y     <= pos_q[1][GRID_BITS-1:0];
				result_q.hit_z     <= pos_q[2][GRID_BITS-1:0];
				if (pfrac < FACE_TOL)
					result_q.face <= {ax_q, 1'b0}
						+ (($signed(dir_q[ax_q]) > 0) ? 3'd1 : 3'd2);
				else
					result_q.face <= FACE_NONE;
			end
			default: ;
		endcase
	end

	assign valid  = valid_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_valid_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(state_q) != S_IDLE)
		else $error("result without a cast in flight");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result.hit |-> result == '0)
		else $error("miss result carries nonzero fields");
	a_chk_follows_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK |-> $past(state_q) == S_RD)
		else $error("store data checked without a read");
	a_dividers_agree: assert property (@(posedge clk) disable iff (!arst_n)
		d_done_a == d_done_b)
		else $error("dividers out of step");
`endif

endmodule

### design/vrt_div.sv
module vrt_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [vrt_pkg::NUM_W-1:0]  num,
	input  logic [vrt_pkg::DIR_W-1:0]  den,
	output logic                       done,
	output logic [vrt_pkg::NUM_W-1:0]  quo
);
	import vrt_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DIR_W-1:0] rem_q;
	logic [DIR_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DIR_W:0]   rem_sh;
	logic             ge;
	logic [DIR_W:0]   diff;

	// one quotient bit per cycle, restoring
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DIR_W-1:0] : rem_sh[DIR_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

### design/vrt_store.sv
module vrt_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [vrt_pkg::ADDR_W-1:0]    wr_addr,
	input  logic [vrt_pkg::BLOCK_BITS-1:0] wr_data,
	input  logic                          rd_en,
	input  logic [vrt_pkg::ADDR_W-1:0]    rd_addr,
	output logic [vrt_pkg::BLOCK_BITS-1:0] rd_data,
	output logic                          clearing
);
	import vrt_pkg::*;

	localparam int DEPTH = 1 << ADDR_W;

	logic [BLOCK_BITS-1:0] mem [DEPTH];
	logic [ADDR_W-1:0]     clr_addr_q;
	logic                  clr_q;
	logic [BLOCK_BITS-1:0] rd_data_q;

	// sweep every entry to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {ADDR_W{1'b1}})
				clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q)
			mem[clr_addr_q] <= '0;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clr_q;

`ifndef SYNTHESIS
	a_no_wr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !wr_en && !rd_en)
		else $error("store access during clearing pass");
`endif

endmodule

### tb/voxel_ray_traversal_tb.sv
module voxel_ray_traversal_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vrt_pkg::*;

	localparam logic [2:0] FACE_XP = 3'd1;
	localparam logic [2:0] FACE_XN = 3'd2;
	localparam logic [2:0] FACE_YP = 3'd3;
	localparam logic [2:0] FACE_YN = 3'd4;
	localparam logic [2:0] FACE_ZP = 3'd5;
	localparam logic [2:0] FACE_ZN = 3'd6;
	localparam logic [2:0] ADDR_EMPTY_CODE = 3'd0;
	localparam logic [2:0] ADDR_UNUSED = 3'd4;
	localparam longint DMAX = (longint'(1) << DIST_W) - 1;
	localparam longint ONE = longint'(1) << FRAC_BITS;

	class ray_scoreboard;
		logic [7:0] voxels [0:(1<<ADDR_W)-1];
		logic [7:0] empty_code;
		result_t hits_due[$];
		int errors, writes, casts, hits;

		function new();
			foreach (voxels[i]) voxels[i] = '0;
			empty_code = '0;
		endfunction

		function bit face_aligned(longint o, longint d, longint t);
			longint a, p;
			a = d * t;
			if (a >= 0)
				p = o + (a >> DIR_FRAC);
			else
				p = o - (((-a) + (ONE * 4 - 1)) >> DIR_FRAC);
			return (p & (ONE - 1)) < longint'(FACE_TOL);
		endfunction

		function result_t trace_ray(item_t it);
			longint org[3], dir[3], pos[3], tmax[3], tdel[3], key[3];
			longint mag, fr, t_walk, maxd;
			bit act[3];
			int ax;
			logic [7:0] blk;
			result_t r;
			r = '0;
			t_walk = 0;
			maxd = it.max_distance;
			org[0] = it.origin_x; org[1] = it.origin_y; org[2] = it.origin_z;
			dir[0] = it.dir_x; dir[1] = it.dir_y; dir[2] = it.dir_z;
			for (int a = 0; a < 3; a++) begin
				pos[a] = org[a] >> FRAC_BITS;
				act[a] = dir[a] != 0;
				tmax[a] = DMAX;
				tdel[a] = DMAX;
				if (act[a]) begin
					mag = dir[a] < 0 ? -dir[a] : dir[a];
					fr = org[a] & (ONE - 1);
					if (dir[a] > 0)
						fr = ONE - fr;
					tmax[a] = (fr << DIR_FRAC) / mag;
					tdel[a] = (ONE << DIR_FRAC) / mag;
					if (tmax[a] > DMAX) tmax[a] = DMAX;
					if (tdel[a] > DMAX) tdel[a] = DMAX;
				end
			end
			while (t_walk <= maxd) begin
				if (pos[0] < 0 || pos[0] > 31 || pos[1] < 0 || pos[1] > 31 ||
				    pos[2] < 0 || pos[2] > 31)
					break;
				blk = voxels[{pos[0][4:0], pos[1][4:0], pos[2][4:0]}];
				if (blk != empty_code) begin
					r.hit = 1'b1;
					r.hit_block = blk;
					r.hit_x = pos[0][4:0];
					r.hit_y = pos[1][4:0];
					r.hit_z = pos[2][4:0];
					if (face_aligned(org[0], dir[0], t_walk))
						r.face = dir[0] > 0 ? FACE_XP : FACE_XN;
					else if (face_aligned(org[1], dir[1], t_walk))
						r.face = dir[1] > 0 ? FACE_YP : FACE_YN;
					else if (face_aligned(org[2], dir[2], t_walk))
						r.face = dir[2] > 0 ? FACE_ZP : FACE_ZN;
					else
						r.face = FACE_NONE;
					return r;
				end
				for (int a = 0; a < 3; a++)
					key[a] = act[a] ? tmax[a] : DMAX + 1;
				if (key[0] < key[1])
					ax = key[0] < key[2] ? 0 : 2;
				else
					ax = key[1] < key[2] ? 1 : 2;
				if (!act[ax])
					break;
				pos[ax] += dir[ax] > 0 ? 1 : -1;
				t_walk = tmax[ax];
				tmax[ax] = tmax[ax] + tdel[ax];
				if (tmax[ax] > DMAX) tmax[ax] = DMAX;
			end
			return r;
		endfunction

		function void note_item(item_t it);
			result_t r;
			if (it.cmd == CMD_WRITE) begin
				voxels[{it.voxel_x, it.voxel_y, it.voxel_z}] = it.block_value;
				writes++;
			end else begin
				r = trace_ray(it);
				hits_due.push_back(r);
				casts++;
				if (r.hit) hits++;
			end
		endfunction

		function void field(string n, int e, int g);
			if (e != g) begin
				$display("%0t: %s expected %0d got %0d", $time, n, e, g);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (hits_due.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			e = hits_due.pop_front();
			field("hit", e.hit, got.hit);
			field("hit_block", e.hit_block, got.hit_block);
			field("hit_x", e.hit_x, got.hit_x);
			field("hit_y", e.hit_y, got.hit_y);
			field("hit_z", e.hit_z, got.hit_z);
			field("face", e.face, got.face);
		endfunction
	endclass

	logic clk, arst_n, start, busy, valid;
	item_t item;
	result_t result;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	ray_scoreboard sb;
	int gap_pct;

	voxel_ray_traversal u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.valid(valid), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_item(item);
		if (arst_n && valid)
			sb.check_result(result);
	end

	task automatic reg_write(logic [2:0] addr, logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {24'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == ADDR_EMPTY_CODE)
			sb.empty_code = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// hold start until the item is taken, then idle at random
	task automatic send(item_t it);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
	endtask

	task automatic settle();
		if (start) begin
			start <= 1'b0;
			@(posedge clk);
		end
		while (sb.hits_due.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic item_t write_item(int x, int y, int z, int v);
		item_t it;
		logic [159:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it = rnd[$bits(item_t)-1:0];
		it.cmd = CMD_WRITE;
		it.voxel_x = 5'(x); it.voxel_y = 5'(y); it.voxel_z = 5'(z);
		it.block_value = 8'(v);
		return it;
	endfunction

	function automatic item_t cast_item(int ox, int oy, int oz, int dx, int dy, int dz,
			int md);
		item_t it;
		logic [159:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it = rnd[$bits(item_t)-1:0];
		it.cmd = CMD_CAST;
		it.origin_x = 17'(ox); it.origin_y = 17'(oy); it.origin_z = 17'(oz);
		it.dir_x = 16'(dx); it.dir_y = 16'(dy); it.dir_z = 16'(dz);
		it.max_distance = 18'(md);
		return it;
	endfunction

	function automatic int rand_dir();
		case ($urandom_range(5))
			0: return 0;
			1: return $urandom_range(1) ? 16384 : -16384;
			default: return int'($urandom_range(32768)) - 16384;
		endcase
	endfunction

	// two thirds of the traffic stays in a small corner so rays find blocks
	function automatic item_t random_item();
		int lim;
		lim = $urandom_range(2) != 0 ? 7 : 31;
		if ($urandom_range(9) < 4)
			return write_item($urandom_range(lim), $urandom_range(lim),
				$urandom_range(lim), $urandom_range(255));
		return cast_item($urandom_range((lim + 1) * 4096 - 1),
			$urandom_range((lim + 1) * 4096 - 1), $urandom_range((lim + 1) * 4096 - 1),
			rand_dir(), rand_dir(), rand_dir(),
			$urandom_range(3) != 0 ? $urandom_range(262143) : $urandom_range(40000));
	endfunction

	initial begin
		logic [7:0] codes[3];
		int idle[3];
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gap_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_write(ADDR_EMPTY_CODE, 8'd0);
		reg_write(ADDR_UNUSED, 8'd77);

		// directed: extremes, ties, empty code, leaving the grid
		gap_pct = 10;
		send(cast_item(2048, 2048, 2048, 0, 0, 0, 262143));
		send(write_item(0, 0, 0, 5));
		send(write_item(31, 31, 31, 255));
		send(write_item(31, 0, 0, 200));
		send(write_item(4, 4, 4, 0));
		send(write_item(5, 5, 5, 9));
		send(cast_item(0, 0, 0, 16384, 16384, 16384, 0));
		send(cast_item(2048, 2048, 2048, 16384, 0, 0, 262143));
		send(cast_item(2048, 2048, 2048, 16384, 0, 0, 4096));
		send(cast_item(131071, 131071, 131071, -16384, -16384, -16384, 262143));
		send(cast_item(126976, 126976, 126976, 16384, 16384, 16384, 262143));
		send(cast_item(6 * 4096, 6 * 4096, 6 * 4096, -16384, -16384, -16384, 262143));
		send(cast_item(3 * 4096, 3 * 4096, 3 * 4096, 9000, 9000, 9000, 262143));
		send(cast_item(4096 + 100, 20000, 20000, -1, 0, 0, 262143));
		send(cast_item(131071, 2048, 2048, 1, 0, 0, 262143));
		send(cast_item(2048, 2048, 2048, -16384, 0, 0, 262143));
		send(cast_item(2048, 20000, 2048, 0, 16384, 1, 262143));
		send(cast_item(0, 0, 4096, 0, 0, -16384, 262143));
		send(cast_item(4096 * 5 + 7, 4096 * 5 + 3000, 4096 * 5 + 2000, 123, -4567,
			16384, 262143));
		send(write_item(0, 0, 0, 0));
		send(cast_item(0, 0, 0, 0, 0, 0, 0));
		settle();

		codes[0] = 8'($urandom_range(1, 254));
		codes[1] = 8'd255;
		codes[2] = 8'd0;
		idle[0] = 22;
		idle[1] = 47;
		idle[2] = 0;
		for (int ph = 0; ph < 3; ph++) begin
			reg_write(ADDR_EMPTY_CODE, codes[ph]);
			gap_pct = idle[ph];
			for (int n = 0; n < 500; n++)
				send(random_item());
			settle();
		end

		repeat (400) @(posedge clk);
		$display("ran %0d voxel writes and %0d casts, %0d of them hits,", sb.writes,
			sb.casts, sb.hits);
		$display("over three air codes and three idle patterns");
		if (sb.errors == 0 && sb.hits_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
